// ----- design/b64se_pkg.sv -----
package b64se_pkg;

   // payload of one input transfer
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // payload of one result transfer
   typedef struct packed {
      logic [6:0] char_code;
      logic       last_char;
   } rsp_type;

   localparam int unsigned GROUP_CHARS = 4;

   // characters produced by one input byte, oldest in entry 0
   typedef struct packed {
      logic [GROUP_CHARS-1:0][6:0] chars;
      logic [2:0]                  count;
      logic                        last;
   } group_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_URL_ALPHABET = 2'd0,
      CSR_LINE_WRAP    = 2'd1
   } csr_index_type;

   localparam logic [6:0] PAD_CHAR     = 7'h3d;
   localparam logic [6:0] NEWLINE_CHAR = 7'h0a;
   localparam logic [5:0] WRAP_BYTES   = 6'd48;

   // six-bit value to its base64 character
   function automatic logic [6:0] sym(input logic [5:0] v, input logic url);
      logic [6:0] r;
      if (v < 6'd26) begin
         r = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
         r = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
         r = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
         r = url ? 7'd45 : 7'd43;
      end else begin
         r = url ? 7'd95 : 7'd47;
      end
      return r;
   endfunction

endpackage

// ----- design/b64se_encoder.sv -----
module b64se_encoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  b64se_pkg::req_type  req_data,
   input  logic                url_alphabet,
   input  logic                line_wrap,
   output b64se_pkg::group_type group
);

   logic [3:0] leftover_ff, leftover_in;
   logic [1:0] phase_ff, phase_in;
   logic [5:0] wrap_count_ff, wrap_count_in;

   logic [7:0] b;
   logic       last;
   logic       group_done;
   logic [5:0] count_inc;

   assign b    = req_data.data_byte;
   assign last = req_data.last_byte;
   assign count_inc = wrap_count_ff + 6'd1;

   // characters and next state for the byte on the input
   always_comb begin
      group.chars = '0;
      group.count = 3'd1;
      group.last  = last;
      group_done  = 1'b0;
      leftover_in = leftover_ff;
      phase_in    = phase_ff;
      wrap_count_in = count_inc;
      case (phase_ff)
         2'd1: begin
            group.chars[0] = b64se_pkg::sym({leftover_ff[1:0], b[7:4]}, url_alphabet);
            leftover_in    = b[3:0];
            phase_in       = 2'd2;
            if (last) begin
               group.chars[1] = b64se_pkg::sym({b[3:0], 2'b00}, url_alphabet);
               group.chars[2] = b64se_pkg::PAD_CHAR;
               group.count    = 3'd3;
            end
         end
         2'd2: begin
            group.chars[0] = b64se_pkg::sym({leftover_ff, b[7:6]}, url_alphabet);
            group.chars[1] = b64se_pkg::sym(b[5:0], url_alphabet);
            group.count    = 3'd2;
            leftover_in    = 4'd0;
            phase_in       = 2'd0;
            group_done     = 1'b1;
         end
         default: begin
            group.chars[0] = b64se_pkg::sym(b[7:2], url_alphabet);
            leftover_in    = {2'b00, b[1:0]};
            phase_in       = 2'd1;
            if (last) begin
               group.chars[1] = b64se_pkg::sym({b[1:0], 4'b0000}, url_alphabet);
               group.chars[2] = b64se_pkg::PAD_CHAR;
               group.chars[3] = b64se_pkg::PAD_CHAR;
               group.count    = 3'd4;
            end
         end
      endcase
      // line break after a full line of input bytes
      if (group_done && count_inc >= b64se_pkg::WRAP_BYTES) begin
         wrap_count_in = 6'd0;
         if (line_wrap) begin
            group.chars[2] = b64se_pkg::NEWLINE_CHAR;
            group.count    = 3'd3;
         end
      end
      // message end returns to the start of a group
      if (last) begin
         leftover_in   = 4'd0;
         phase_in      = 2'd0;
         wrap_count_in = 6'd0;
      end
   end

   // group state
   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff   <= 4'd0;
         phase_ff      <= 2'd0;
         wrap_count_ff <= 6'd0;
      end else if (accept) begin
         leftover_ff   <= leftover_in;
         phase_ff      <= phase_in;
         wrap_count_ff <= wrap_count_in;
      end
   end

`ifndef SYNTHESIS
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("group phase left its range");
   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      wrap_count_ff < b64se_pkg::WRAP_BYTES)
      else $error("line byte count past a full line");
   a_group_start_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == 2'd0 |-> leftover_ff == 4'd0)
      else $error("leftover bits kept at group start");
`endif

endmodule

// ----- design/b64se_out_buf.sv -----
module b64se_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  b64se_pkg::group_type group,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output b64se_pkg::rsp_type   rsp_data
);

   localparam int unsigned N = b64se_pkg::GROUP_CHARS;

   logic [N-1:0][6:0] chars_ff, chars_in;
   logic [2:0]        count_ff, count_in;
   logic              last_ff, last_in;
   logic              xfer;

   assign xfer      = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != 3'd0;
   assign free      = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_ready);

   assign rsp_data.char_code = chars_ff[0];
   assign rsp_data.last_char = last_ff && count_ff == 3'd1;

   // load a fresh group or shift out the oldest character
   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load) begin
         chars_in = group.chars;
         count_in = group.count;
         last_in  = group.last;
      end else if (xfer) begin
         chars_in = {7'd0, chars_ff[N-1:1]};
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(N))
      else $error("character count over buffer depth");
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> count_ff == $past(group.count))
      else $error("loaded group lost or merged");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      xfer && count_ff == 3'd1 && !load |=> count_ff == 3'd0)
      else $error("buffer not empty after final character");
`endif

endmodule

// ----- design/base64_stream_encoder.sv -----
// base64 stream encoder
// input channel req_*: one raw byte per transfer, last_byte marks the end
// of a message. result channel rsp_*: one ascii character per transfer,
// last_char on the final character of the message (padding, newline or data).
// config channel csr_*: index 0 selects the url-safe alphabet, index 1
// turns on a newline after every 48 input bytes; always ready, write only
// between messages.
// each byte yields 1 to 4 characters, held in a four-entry output buffer
// that sends one character per cycle while rsp_ready is high. the first
// character of a byte is on rsp in the cycle after its input transfer. a
// new byte is taken in the cycle the buffer sends its final character, so
// throughput is set by the output port.
// a receiver stall holds the buffer and with it req_ready.
// reset (synchronous) empties the buffer, clears the group position and
// line count, and selects the standard alphabet with no line breaks.
module base64_stream_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b64se_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64se_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic               csr_wdata
);

   logic                 url_ff;
   logic                 wrap_ff;
   logic                 accept;
   logic                 free;
   b64se_pkg::group_type group;

   assign csr_ready = 1'b1;
   assign req_ready = free;
   assign accept    = req_valid && free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         url_ff  <= 1'b0;
         wrap_ff <= 1'b0;
      end else if (csr_valid) begin
         case (b64se_pkg::csr_index_type'(csr_index))
            b64se_pkg::CSR_URL_ALPHABET: url_ff  <= csr_wdata;
            b64se_pkg::CSR_LINE_WRAP:    wrap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   b64se_encoder u_encoder (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .url_alphabet (url_ff),
      .line_wrap    (wrap_ff),
      .group        (group)
   );

   b64se_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .group     (group),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/tb_base64_stream_encoder.sv -----
module tb_base64_stream_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   // csr indexes that map to no register, writes there are ignored
   localparam logic [1:0] CSR_RESERVED_LO = 2'd2;
   localparam logic [1:0] CSR_RESERVED_HI = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   b64se_pkg::req_type  req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   b64se_pkg::rsp_type  rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic                csr_wdata;

   base64_stream_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // directed stimulus: a byte or a csr write, with the characters typed in where obvious
   typedef enum {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   data;     // byte, or csr index in the low bits
      logic         flag;     // last_byte, or csr write data
      string        chars;    // characters caused by the byte, empty: use the encoder
   } row_type;

   row_type dir_rows[24] = '{
      '{ROW_BYTE, 8'h00, 1'b1, "AA=="},
      '{ROW_BYTE, 8'hff, 1'b1, "/w=="},
      '{ROW_BYTE, 8'hfb, 1'b0, "+"},
      '{ROW_BYTE, 8'hff, 1'b0, "/"},
      '{ROW_BYTE, 8'hbf, 1'b1, "+/"},
      '{ROW_BYTE, 8'h00, 1'b0, "A"},
      '{ROW_BYTE, 8'hff, 1'b1, "P8="},
      '{ROW_CSR,  {6'd0, b64se_pkg::CSR_URL_ALPHABET}, 1'b1, ""},
      '{ROW_BYTE, 8'hfb, 1'b0, "-"},
      '{ROW_BYTE, 8'hff, 1'b0, "_"},
      '{ROW_BYTE, 8'hbf, 1'b1, "-_"},
      '{ROW_BYTE, 8'h80, 1'b1, "gA=="},
      '{ROW_BYTE, 8'h7f, 1'b1, ""},
      '{ROW_BYTE, 8'h3c, 1'b0, ""},
      '{ROW_BYTE, 8'ha5, 1'b0, ""},
      '{ROW_BYTE, 8'h7e, 1'b0, ""},
      '{ROW_BYTE, 8'h01, 1'b1, ""},
      '{ROW_CSR,  {6'd0, CSR_RESERVED_HI}, 1'b1, ""},
      '{ROW_CSR,  {6'd0, CSR_RESERVED_LO}, 1'b0, ""},
      '{ROW_CSR,  {6'd0, b64se_pkg::CSR_LINE_WRAP}, 1'b1, ""},
      '{ROW_BYTE, 8'h55, 1'b0, ""},
      '{ROW_BYTE, 8'haa, 1'b1, ""},
      '{ROW_CSR,  {6'd0, b64se_pkg::CSR_LINE_WRAP}, 1'b0, ""},
      '{ROW_CSR,  {6'd0, b64se_pkg::CSR_URL_ALPHABET}, 1'b0, ""}
   };

   string std_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   string url_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   // encoder state and settings as the block should hold them
   logic       url_mode;
   logic       wrap_mode;
   logic [3:0] left_bits;
   logic [1:0] group_pos;
   logic [5:0] line_bytes;

   b64se_pkg::rsp_type char_buf[5];
   int                 char_count;
   b64se_pkg::rsp_type pending_chars[$];
   int                 error_count = 0;
   int                 burst_left = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_base64_stream_encoder: errors");
      $finish;
   end

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      byte ch;
      ch = url_mode ? url_chars[v] : std_chars[v];
      return ch[6:0];
   endfunction

   function automatic void add_char(input logic [6:0] code);
      char_buf[char_count].char_code = code;
      char_buf[char_count].last_char = 1'b0;
      char_count++;
   endfunction

   // characters caused by one byte, into char_buf; advances the encoder state
   function automatic void encode_byte(input b64se_pkg::req_type item);
      logic [7:0] b;
      logic       group_end;
      b = item.data_byte;
      group_end = 1'b0;
      char_count = 0;
      if (group_pos == 2'd1) begin
         add_char(b64_char({left_bits[1:0], b[7:4]}));
         left_bits = b[3:0];
         group_pos = 2'd2;
         if (item.last_byte) begin
            add_char(b64_char({left_bits, 2'b00}));
            add_char(b64se_pkg::PAD_CHAR);
         end
      end else if (group_pos == 2'd2) begin
         add_char(b64_char({left_bits, b[7:6]}));
         add_char(b64_char(b[5:0]));
         left_bits = 4'd0;
         group_pos = 2'd0;
         group_end = 1'b1;
      end else begin
         add_char(b64_char(b[7:2]));
         left_bits = {2'b00, b[1:0]};
         group_pos = 2'd1;
         if (item.last_byte) begin
            add_char(b64_char({left_bits[1:0], 4'd0}));
            add_char(b64se_pkg::PAD_CHAR);
            add_char(b64se_pkg::PAD_CHAR);
         end
      end
      // line count runs even with wrapping off
      line_bytes = line_bytes + 6'd1;
      if (group_end && line_bytes >= b64se_pkg::WRAP_BYTES) begin
         line_bytes = 6'd0;
         if (wrap_mode) begin
            add_char(b64se_pkg::NEWLINE_CHAR);
         end
      end
      if (item.last_byte) begin
         char_buf[char_count-1].last_char = 1'b1;
         left_bits = 4'd0;
         group_pos = 2'd0;
         line_bytes = 6'd0;
      end
   endfunction

   // one byte transfer in bursts with random gaps; returns at a falling edge
   // with req_valid still high, the caller drives it on in the same step
   task automatic send_byte(input b64se_pkg::req_type item, input string fixed);
      int                 gap;
      byte                ch;
      b64se_pkg::rsp_type exp_char;
      csr_valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_byte(item);
      if (fixed.len() != 0) begin
         for (int k = 0; k < fixed.len(); k++) begin
            ch = fixed[k];
            exp_char.char_code = ch[6:0];
            exp_char.last_char = item.last_byte && (k == fixed.len() - 1);
            pending_chars.push_back(exp_char);
         end
      end else begin
         for (int k = 0; k < char_count; k++) begin
            pending_chars.push_back(char_buf[k]);
         end
      end
      @(negedge clock);
   endtask

   // stop sending and wait until every expected character has come out
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_chars.size() != 0) @(negedge clock);
   endtask

   // csr write transfer; csr_valid is lowered by the next send_byte
   task automatic csr_write(input logic [1:0] idx, input logic value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == b64se_pkg::CSR_URL_ALPHABET) begin
         url_mode = value;
      end else if (idx == b64se_pkg::CSR_LINE_WRAP) begin
         wrap_mode = value;
      end
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      b64se_pkg::req_type item;
      for (int k = 0; k < len; k++) begin
         item.data_byte = $urandom_range(0, 255);
         item.last_byte = (k == len - 1);
         send_byte(item, "");
      end
   endtask

   // receiver: random ready pattern, drawn from four modes
   initial begin
      int mode;
      int hold;
      int cyc;
      mode = 0;
      hold = 0;
      cyc = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (cyc % 40 == 0) begin
            mode = $urandom_range(0, 3);
         end
         cyc++;
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 2) != 0);
               2: rsp_ready <= (cyc % 4 == 0);
               default: begin
                  if ($urandom_range(0, 7) == 0) begin
                     hold = $urandom_range(4, 12);
                     rsp_ready <= 1'b0;
                  end else begin
                     rsp_ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // compare each character transfer with the oldest expected one
   always @(posedge clock) begin
      b64se_pkg::rsp_type exp_char;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character transfer: char_code %h last_char %b",
                   rsp_data.char_code, rsp_data.last_char);
            error_count++;
         end else begin
            exp_char = pending_chars.pop_front();
            if (rsp_data.char_code !== exp_char.char_code) begin
               $error("char_code: expected %h, got %h", exp_char.char_code,
                      rsp_data.char_code);
               error_count++;
            end
            if (rsp_data.last_char !== exp_char.last_char) begin
               $error("last_char: expected %b, got %b", exp_char.last_char,
                      rsp_data.last_char);
               error_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      b64se_pkg::req_type item;
      int                 sent;
      int                 len;
      logic               setting_url[4];
      logic               setting_wrap[4];
      setting_url  = '{1'b0, 1'b1, 1'b1, 1'b0};
      setting_wrap = '{1'b1, 1'b1, 1'b0, 1'b0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = 1'b0;
      url_mode = 1'b0;
      wrap_mode = 1'b0;
      left_bits = 4'd0;
      group_pos = 2'd0;
      line_bytes = 6'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < $size(dir_rows); r++) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            drain();
            csr_write(dir_rows[r].data[1:0], dir_rows[r].flag);
         end else begin
            item.data_byte = dir_rows[r].data;
            item.last_byte = dir_rows[r].flag;
            send_byte(item, dir_rows[r].chars);
         end
      end

      // random messages under each alphabet and wrap setting
      for (int p = 0; p < 4; p++) begin
         drain();
         csr_write(b64se_pkg::CSR_URL_ALPHABET, setting_url[p]);
         csr_write(b64se_pkg::CSR_LINE_WRAP, setting_wrap[p]);
         // a full line ending exactly on the last byte, or a line break inside
         len = (p % 2 == 0) ? 48 : 50;
         send_message(len);
         sent = len;
         while (sent < 50) begin
            if ($urandom_range(0, 5) == 0) begin
               len = $urandom_range(5, 8);
            end else begin
               len = $urandom_range(1, 4);
            end
            send_message(len);
            sent += len;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_base64_stream_encoder: clean");
      end else begin
         $display("tb_base64_stream_encoder: errors");
      end
      $finish;
   end

endmodule
